// ===== hw/rtl/tnd_pkg.sv =====
`timescale 1ns / 1ps
package tnd_pkg;
    localparam int TABLE_ENTRIES_DEF  = 1024;
    localparam int MAX_NEIGHBOURS_DEF = 5;
    localparam int ID_W               = 16;
    localparam int CNT_MAX            = 16'hFFFF;
    localparam logic [2:0] DEGREE_LIMIT_RESET = 3'd5;
endpackage

// ===== hw/rtl/tnd_ram.sv =====
`timescale 1ns / 1ps
module tnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/twin_node_detector.sv =====
`timescale 1ns / 1ps
// A node is sorted one compare-exchange pass per cycle; then each stored set is read in
// ST_SCAN and compared in ST_CMP until one matches or the scan reaches the fill count,
// and the result is handed off through ST_OUT. A new node is taken only in ST_IDLE and
// only once the previous result has been accepted. A node above the degree limit skips
// the sort and the scan and goes straight to ST_OUT. Reset (rst_n, asynchronous, active
// low) empties the table.
module twin_node_detector
    import tnd_pkg::*;
#(
    parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
    parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // node_id[15:0], degree[31:16], neighbour_k at 32+16k, zero padded
    input  logic [ID_W*(2+MAX_NEIGHBOURS)-1:0] s_axis_tdata,
    // first_node
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // result_node[15:0], is_twin[16], representative[32:17], twin_total[48:33],
    // table_overflow[49], zero padded to 56 bits
    output logic [55:0] m_axis_tdata,
    input  logic cfg_we,
    input  logic [2:0] cfg_wdata
);
    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int NW  = $clog2(MAX_NEIGHBOURS + 1);
    localparam int KW  = ID_W * MAX_NEIGHBOURS + NW;
    localparam int CW  = AW + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SORT  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] limit_reg;
    logic [CW-1:0] used_reg, used_next;
    logic [15:0] count_reg, count_next;
    logic [ID_W-1:0] node_reg;
    logic [ID_W-1:0] ids_reg [MAX_NEIGHBOURS];
    logic [ID_W-1:0] ids_next [MAX_NEIGHBOURS];
    logic [MAX_NEIGHBOURS-1:0] act_reg, act_next;
    logic [NW-1:0] pass_reg, pass_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] raddr;
    logic [KW-1:0] key_rd, key_wr;
    logic [ID_W-1:0] own_rd;
    logic we;
    logic [55:0] out_reg, out_next;
    logic ov_valid_reg;

    // The key word holds the sorted distinct ids (zero filled) and the distinct count.
    logic [ID_W*MAX_NEIGHBOURS-1:0] key_ids;
    logic [NW-1:0] distinct;
    logic [2:0] lim_eff;
    logic [15:0] deg_in;

    assign deg_in = s_axis_tdata[2*ID_W-1:ID_W];
    assign lim_eff = (32'(limit_reg) > MAX_NEIGHBOURS) ? 3'(MAX_NEIGHBOURS) : limit_reg;

    always_comb
    begin
        logic [ID_W-1:0] prev;
        logic have;
        int m;
        key_ids = '0;
        prev = '0;
        have = 1'b0;
        m = 0;
        for (int k = 0; k < MAX_NEIGHBOURS; k++)
        begin
            if (act_reg[k] && (!have || ids_reg[k] != prev))
            begin
                key_ids[ID_W*m +: ID_W] = ids_reg[k];
                m = m + 1;
            end
            if (act_reg[k])
            begin
                prev = ids_reg[k];
                have = 1'b1;
            end
        end
        distinct = NW'(m);
    end

    assign key_wr = {distinct, key_ids};
    assign raddr = idx_reg[AW-1:0];
    assign we = (state_reg == ST_SCAN) && (idx_reg == used_reg) &&
                (32'(used_reg) < TABLE_ENTRIES);

    tnd_ram #(.WIDTH(KW), .DEPTH(TABLE_ENTRIES)) u_key (
        .clk(clk), .we(we), .waddr(used_reg[AW-1:0]), .wdata(key_wr),
        .raddr(raddr), .rdata(key_rd)
    );
    tnd_ram #(.WIDTH(ID_W), .DEPTH(TABLE_ENTRIES)) u_owner (
        .clk(clk), .we(we), .waddr(used_reg[AW-1:0]), .wdata(node_reg),
        .raddr(raddr), .rdata(own_rd)
    );

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_valid_reg;
    assign m_axis_tvalid = ov_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        act_next   = act_reg;
        out_next   = out_reg;
        for (int k = 0; k < MAX_NEIGHBOURS; k++)
        begin
            ids_next[k] = ids_reg[k];
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (s_axis_tuser)
                    begin
                        used_next  = '0;
                        count_next = '0;
                    end
                    for (int k = 0; k < MAX_NEIGHBOURS; k++)
                    begin
                        ids_next[k] = s_axis_tdata[ID_W*(2+k) +: ID_W];
                        act_next[k] = 32'(deg_in) > k;
                    end
                    pass_next = '0;
                    idx_next  = '0;
                    if (deg_in > 16'(lim_eff))
                    begin
                        out_next = {6'd0, 1'b0,
                                    (s_axis_tuser ? 16'd0 : count_reg),
                                    16'd0, 1'b0, s_axis_tdata[ID_W-1:0]};
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT:
            begin
                // Odd-even transposition: MAX_NEIGHBOURS passes sort the active ids.
                for (int k = 0; k + 1 < MAX_NEIGHBOURS; k++)
                begin
                    if (((k % 2) == 1) == pass_reg[0] && act_reg[k+1] &&
                        ids_reg[k] > ids_reg[k+1])
                    begin
                        ids_next[k]   = ids_reg[k+1];
                        ids_next[k+1] = ids_reg[k];
                    end
                end
                pass_next = pass_reg + 1'b1;
                if (32'(pass_reg) + 1 >= MAX_NEIGHBOURS)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Entry idx is being read; at the fill count the scan has missed.
                if (idx_reg == used_reg)
                begin
                    if (32'(used_reg) < TABLE_ENTRIES)
                    begin
                        used_next = used_reg + 1'b1;
                        out_next  = {6'd0, 1'b0, count_reg, 16'd0, 1'b0, node_reg};
                    end
                    else
                    begin
                        out_next  = {6'd0, 1'b1, count_reg, 16'd0, 1'b0, node_reg};
                    end
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (key_rd == key_wr)
                begin
                    if (count_reg != 16'(CNT_MAX))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    out_next = {6'd0, 1'b0,
                                (count_reg != 16'(CNT_MAX) ? count_reg + 1'b1 : count_reg),
                                own_rd, 1'b1, node_reg};
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            limit_reg    <= DEGREE_LIMIT_RESET;
            used_reg     <= '0;
            count_reg    <= '0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (state_reg == ST_OUT)
            begin
                ov_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid && s_axis_tready)
        begin
            node_reg <= s_axis_tdata[ID_W-1:0];
        end
        idx_reg  <= idx_next;
        pass_reg <= pass_next;
        act_reg  <= act_next;
        out_reg  <= out_next;
        for (int k = 0; k < MAX_NEIGHBOURS; k++)
        begin
            ids_reg[k] <= ids_next[k];
        end
    end

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= TABLE_ENTRIES) else $error("fill count beyond table");
    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> used_reg == $past(used_reg) + 1'b1) else $error("write without fill step");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ov_valid_reg |-> !s_axis_tready) else $error("accept while result pending");
endmodule
